@@ rtl/pfsl_pkg.sv @@
`default_nettype none
package pfsl_pkg;

  localparam int PHASES    = 4;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int THR_W     = 16;
  localparam int SUM_W     = DATA_W + $clog2(PHASES);
  localparam int PROD_W    = DATA_W + FRAC_BITS;
  localparam int LATENCY   = FRAC_BITS + 4;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_POS  = 2'd1,
    SIDE_NEG  = 2'd2
  } side_t;

  typedef struct packed {
    logic [PHASES-1:0][DATA_W-1:0] mag;
    logic [PHASES-1:0]             neg;
    logic [PHASES-1:0]             hit;
    side_t                         side;
    logic [FRAC_BITS-1:0]          quo;
    logic [SUM_W-1:0]              rem;
    logic [SUM_W-1:0]              den;
  } lane_t;

endpackage
`default_nettype wire

@@ rtl/pfsl_front.sv @@
`default_nettype none
module pfsl_front
  import pfsl_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [PHASES-1:0][DATA_W-1:0] corr,
  input  wire logic [THR_W-1:0]              threshold,
  output logic                               out_valid,
  output lane_t                              out_lane
);

  logic                          s1_valid;
  logic [PHASES-1:0][DATA_W-1:0] s1_mag;
  logic [PHASES-1:0]             s1_nz;
  logic [SUM_W-1:0]              s1_pos;
  logic [SUM_W-1:0]              s1_neg;

  logic [PHASES-1:0][DATA_W-1:0] mag_next;
  logic [PHASES-1:0]             nz_next;
  logic [SUM_W-1:0]              pos_next;
  logic [SUM_W-1:0]              neg_next;
  lane_t                         lane_next;
  logic [SUM_W-1:0]              thr_ext;

  always_comb begin
    pos_next = '0;
    neg_next = '0;
    for (int i = 0; i < PHASES; i++) begin
      mag_next[i] = corr[i][DATA_W-1] ? (~corr[i] + 1'b1) : corr[i];
      nz_next[i]  = corr[i][DATA_W-1] || (corr[i] == '0);
      if (nz_next[i]) begin
        neg_next = neg_next + SUM_W'(mag_next[i]);
      end else begin
        pos_next = pos_next + SUM_W'(mag_next[i]);
      end
    end
  end

  always_comb begin
    thr_ext        = SUM_W'(threshold);
    lane_next.mag  = s1_mag;
    lane_next.neg  = s1_nz;
    lane_next.quo  = '0;
    lane_next.side = SIDE_NONE;
    lane_next.hit  = '0;
    lane_next.rem  = '0;
    lane_next.den  = SUM_W'(1);
    if (s1_pos > s1_neg && s1_pos > thr_ext) begin
      lane_next.side = SIDE_POS;
      lane_next.hit  = ~s1_nz;
      lane_next.rem  = s1_neg;
      lane_next.den  = s1_pos;
    end else if (s1_neg > s1_pos && s1_neg > thr_ext) begin
      lane_next.side = SIDE_NEG;
      lane_next.hit  = s1_nz;
      lane_next.rem  = s1_pos;
      lane_next.den  = s1_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
    s1_mag   <= mag_next;
    s1_nz    <= nz_next;
    s1_pos   <= pos_next;
    s1_neg   <= neg_next;
    out_lane <= lane_next;
  end

endmodule
`default_nettype wire

@@ rtl/pfsl_div_cell.sv @@
`default_nettype none
module pfsl_div_cell
  import pfsl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire lane_t in_lane,
  output logic       out_valid,
  output lane_t      out_lane
);

  logic [SUM_W:0] twice;
  logic           ge;
  lane_t          lane_next;

  always_comb begin
    twice         = {in_lane.rem, 1'b0};
    ge            = twice >= {1'b0, in_lane.den};
    lane_next     = in_lane;
    lane_next.quo = {in_lane.quo[FRAC_BITS-2:0], ge};
    lane_next.rem = ge ? SUM_W'(twice - {1'b0, in_lane.den}) : twice[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_lane <= lane_next;
  end

endmodule
`default_nettype wire

@@ rtl/pfsl_scale.sv @@
`default_nettype none
module pfsl_scale
  import pfsl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire lane_t                    in_lane,
  output logic                          out_valid,
  output logic [PHASES-1:0][DATA_W-1:0] out_val,
  output side_t                         out_side
);

  logic                          p_valid;
  logic [PHASES-1:0][PROD_W-1:0] p_prod;
  logic [PHASES-1:0][DATA_W-1:0] p_mag;
  logic [PHASES-1:0]             p_neg;
  logic [PHASES-1:0]             p_hit;
  side_t                         p_side;

  logic [PHASES-1:0][PROD_W-1:0] prod_next;
  logic [PHASES-1:0][DATA_W-1:0] val_next;
  logic [DATA_W-1:0]             m;

  always_comb begin
    for (int i = 0; i < PHASES; i++) begin
      prod_next[i] = PROD_W'(in_lane.mag[i]) * PROD_W'(in_lane.quo);
    end
  end

  always_comb begin
    for (int i = 0; i < PHASES; i++) begin
      m           = p_hit[i] ? p_prod[i][PROD_W-1:FRAC_BITS] : p_mag[i];
      val_next[i] = p_neg[i] ? (~m + 1'b1) : m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
    p_prod   <= prod_next;
    p_mag    <= in_lane.mag;
    p_neg    <= in_lane.neg;
    p_hit    <= in_lane.hit;
    p_side   <= in_lane.side;
    out_val  <= val_next;
    out_side <= p_side;
  end

endmodule
`default_nettype wire

@@ rtl/phase_flux_sum_limiter_unit.sv @@
// Phase flux sum limiter.
// A request is taken on every rising edge with start high; busy is always low,
// so a new face may be presented in every cycle. The four corrections are
// signed Q16.16 values.
// Each result appears on out_0 to out_3 and scaled_side for one cycle with
// done high, in request order. Throughput is one face per cycle. The block is
// a row of sixteen divider cells, each producing one bit of the limiting
// ratio, plus two front stages that form the side totals and two back stages
// that multiply and restore the sign.
// The receiver cannot stall the block, and none is needed since every stage
// advances in every cycle.
// The threshold is written through cfg_valid and cfg_data; cfg_ready is always
// high. It should only be changed while no request is in flight.
// A synchronous reset empties the pipeline and sets the threshold to one.
`default_nettype none
module phase_flux_sum_limiter_unit
  import pfsl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DATA_W-1:0] corr_0,
  input  wire logic [DATA_W-1:0] corr_1,
  input  wire logic [DATA_W-1:0] corr_2,
  input  wire logic [DATA_W-1:0] corr_3,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [THR_W-1:0]  cfg_data,
  output logic                   done,
  output logic [DATA_W-1:0]      out_0,
  output logic [DATA_W-1:0]      out_1,
  output logic [DATA_W-1:0]      out_2,
  output logic [DATA_W-1:0]      out_3,
  output logic [1:0]             scaled_side
);

  logic [THR_W-1:0]              threshold;
  logic [PHASES-1:0][DATA_W-1:0] corr;
  logic [PHASES-1:0][DATA_W-1:0] res;
  side_t                         side;
  logic [FRAC_BITS:0]            chain_valid;
  lane_t                         chain_lane [FRAC_BITS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign corr      = {corr_3, corr_2, corr_1, corr_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  pfsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .corr      (corr),
    .threshold (threshold),
    .out_valid (chain_valid[0]),
    .out_lane  (chain_lane[0])
  );

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_cell
    pfsl_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_lane   (chain_lane[g]),
      .out_valid (chain_valid[g+1]),
      .out_lane  (chain_lane[g+1])
    );
  end

  pfsl_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[FRAC_BITS]),
    .in_lane   (chain_lane[FRAC_BITS]),
    .out_valid (done),
    .out_val   (res),
    .out_side  (side)
  );

  assign out_0       = res[0];
  assign out_1       = res[1];
  assign out_2       = res[2];
  assign out_3       = res[3];
  assign scaled_side = side;

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY)) else $error("result without a request");

  a_side_code: assert property (@(posedge clk) disable iff (rst)
    done |-> scaled_side != 2'd3) else $error("invalid scaled side");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (done && scaled_side == SIDE_NONE) |-> out_0 == $past(corr_0, LATENCY))
    else $error("unscaled correction altered");

  a_not_busy: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready) else $error("block refused a request");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
  import pfsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] c0, c1, c2, c3;
  } face_t;

  typedef struct packed {
    logic [DATA_W-1:0] o0, o1, o2, o3;
    side_t             side;
  } limited_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [DATA_W-1:0] corr_0 = '0, corr_1 = '0, corr_2 = '0, corr_3 = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;
  logic done;
  logic [DATA_W-1:0] out_0, out_1, out_2, out_3;
  logic [1:0] scaled_side;

  phase_flux_sum_limiter_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corr_0(corr_0), .corr_1(corr_1), .corr_2(corr_2), .corr_3(corr_3),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .out_0(out_0), .out_1(out_1), .out_2(out_2), .out_3(out_3),
    .scaled_side(scaled_side)
  );

  always #2 clk = ~clk;

  face_t    pending_faces[$];
  limited_t expected_faces[$];
  logic [THR_W-1:0] threshold = 1;
  int unsigned send_idle_pct = 0;
  bit hold_sender = 1'b0;
  int errors = 0;
  longint unsigned cycles = 0;

  function automatic limited_t limit_face(face_t f);
    logic [DATA_W-1:0] v[4];
    logic [63:0] mag[4];
    bit negside[4];
    logic [63:0] pos_total, neg_total, num, den, rem, ratio, m;
    logic [DATA_W-1:0] r[4];
    side_t side;
    limited_t res;
    v[0] = f.c0; v[1] = f.c1; v[2] = f.c2; v[3] = f.c3;
    pos_total = 0;
    neg_total = 0;
    for (int i = 0; i < 4; i++) begin
      if (v[i][DATA_W-1]) mag[i] = 64'(DATA_W'(~v[i] + 1'b1));
      else mag[i] = 64'(v[i]);
      negside[i] = v[i][DATA_W-1] || v[i] == 0;
      if (negside[i]) neg_total += mag[i];
      else pos_total += mag[i];
    end
    side = SIDE_NONE;
    ratio = 0;
    if (pos_total > neg_total && pos_total > threshold) begin
      side = SIDE_POS; num = neg_total; den = pos_total;
    end else if (neg_total > pos_total && neg_total > threshold) begin
      side = SIDE_NEG; num = pos_total; den = neg_total;
    end
    if (side != SIDE_NONE) ratio = (num << FRAC_BITS) / den;
    for (int i = 0; i < 4; i++) begin
      m = mag[i];
      if ((side == SIDE_POS && !negside[i]) || (side == SIDE_NEG && negside[i]))
        m = (m * ratio) >> FRAC_BITS;
      r[i] = negside[i] ? DATA_W'(-m) : DATA_W'(m);
    end
    res.o0 = r[0]; res.o1 = r[1]; res.o2 = r[2]; res.o3 = r[3];
    res.side = side;
    return res;
  endfunction

  always @(negedge clk) begin
    if (rst || hold_sender || pending_faces.size() == 0 ||
        $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      corr_0 <= pending_faces[0].c0;
      corr_1 <= pending_faces[0].c1;
      corr_2 <= pending_faces[0].c2;
      corr_3 <= pending_faces[0].c3;
    end
  end

  always @(posedge clk) begin
    face_t f;
    limited_t e;
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      f = pending_faces.pop_front();
      expected_faces.push_back(limit_face(f));
    end
    if (!rst && done) begin
      if (expected_faces.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_faces.pop_front();
        if (out_0 !== e.o0) begin
          $error("out_0 exp %h got %h", e.o0, out_0); errors++;
        end
        if (out_1 !== e.o1) begin
          $error("out_1 exp %h got %h", e.o1, out_1); errors++;
        end
        if (out_2 !== e.o2) begin
          $error("out_2 exp %h got %h", e.o2, out_2); errors++;
        end
        if (out_3 !== e.o3) begin
          $error("out_3 exp %h got %h", e.o3, out_3); errors++;
        end
        if (scaled_side !== e.side) begin
          $error("scaled_side exp %0d got %0d", e.side, scaled_side); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand_corr();
    case ($urandom_range(5))
      0: return DATA_W'($urandom_range(65535 * 3)) - DATA_W'(65535);
      1: return {$urandom} >> $urandom_range(31);
      2: return -({$urandom} >> $urandom_range(31));
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_face(logic [DATA_W-1:0] a, b, c, d);
    face_t f;
    f.c0 = a; f.c1 = b; f.c2 = c; f.c3 = d;
    pending_faces.push_back(f);
  endtask

  task automatic drain();
    while (pending_faces.size() != 0 || expected_faces.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] t);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold = t;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_faces(int n);
    for (int i = 0; i < n; i++) add_face(rand_corr(), rand_corr(), rand_corr(), rand_corr());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    add_face('0, '0, '0, '0);
    add_face(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_face(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, '0);
    add_face(32'h0001_0000, 32'hffff_0000, '0, '0);
    add_face(32'h0000_0001, '0, '0, '0);
    add_face(32'h0000_0002, '0, '0, '0);
    add_face(32'hffff_fffe, '0, '0, '0);
    add_face(32'h0003_0000, 32'hffff_0000, 32'h0000_8000, '0);
    add_face(32'hfffd_0000, 32'h0001_0000, 32'hffff_8000, '0);
    add_face(32'h7fff_ffff, 32'hffff_ffff, '0, '0);
    add_face(32'h8000_0000, 32'h0000_0001, '0, '0);
    drain();
    write_threshold(16'hffff);
    add_face(32'h0000_ffff, '0, '0, '0);
    add_face(32'h0001_0000, '0, '0, '0);
    add_face(32'hffff_0001, '0, '0, '0);
    add_face(32'hffff_0000, '0, '0, '0);
    drain();
    write_threshold(16'h0000);
    add_face(32'h0000_0001, '0, '0, '0);
    add_face(32'hffff_ffff, '0, '0, '0);
    random_faces(100);
    drain();
    send_idle_pct = 33;
    write_threshold(16'h1234);
    random_faces(350);
    while (pending_faces.size() > 200) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_faces.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();
    send_idle_pct = 75;
    write_threshold(16'($urandom));
    random_faces(300);
    drain();
    send_idle_pct = 0;
    write_threshold(16'h0001);
    random_faces(380);
    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/pfsl_pkg.sv
rtl/pfsl_front.sv
rtl/pfsl_div_cell.sv
rtl/pfsl_scale.sv
rtl/phase_flux_sum_limiter_unit.sv
tb/tb.sv
